### src/info_frame_receiver_assert.svh
// ---------------------------------------------------------------------------
// info_frame_receiver_assert
// Assertion macros for the frame receiver. Expects clk and rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef INFO_FRAME_RECEIVER_ASSERT_SVH
`define INFO_FRAME_RECEIVER_ASSERT_SVH

// same-cycle implication
`define IFR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IFR_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/ifr_pkg.sv
// ---------------------------------------------------------------------------
// ifr_pkg
// Shared types and constants of the information frame receiver.
// ---------------------------------------------------------------------------
package ifr_pkg;

    localparam int BYTE_W     = 8;
    localparam int KIND_W     = 2;
    localparam int LEN_W      = 11;
    localparam int APB_DATA_W = 32;
    localparam int CFG_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;
    localparam int QDEPTH     = 2;  // power of two

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_FLAG = 3'd1,
        PH_ADDR = 3'd2,
        PH_CTRL = 3'd3,
        PH_DATA = 3'd4,
        PH_ESC  = 3'd5,
        PH_DONE = 3'd6,
        PH_OVF  = 3'd7
    } ifr_phase_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_BYTE = 2'd0,
        KIND_GOOD = 2'd1,
        KIND_BAD  = 2'd2,
        KIND_OVF  = 2'd3
    } ifr_kind_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_EXP_CTRL = 3'd0,
        REG_ADDRESS  = 3'd1,
        REG_FLAG     = 3'd2,
        REG_ESCAPE   = 3'd3,
        REG_ESC_FLAG = 3'd4,
        REG_ESC_ESC  = 3'd5
    } ifr_reg_idx_t;

    typedef struct packed {
        logic [BYTE_W-1:0] expected_control;
        logic [BYTE_W-1:0] address_byte;
        logic [BYTE_W-1:0] flag_byte;
        logic [BYTE_W-1:0] escape_byte;
        logic [BYTE_W-1:0] escaped_flag_code;
        logic [BYTE_W-1:0] escaped_escape_code;
    } ifr_cfg_t;

    typedef struct packed {
        logic [KIND_W-1:0] result_kind;
        logic [BYTE_W-1:0] payload_byte;
        logic [LEN_W-1:0]  payload_length;
    } ifr_result_t;

endpackage

### src/ifr_in_if.sv
// ---------------------------------------------------------------------------
// ifr_in_if
// Input channel: one received byte or a restart per item.
// ---------------------------------------------------------------------------
interface ifr_in_if;
    logic                        valid;
    logic                        ready;
    logic                        action;
    logic [ifr_pkg::BYTE_W-1:0]  rx_byte;

    modport source (output valid, output action, output rx_byte, input ready);
    modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

### src/ifr_out_if.sv
// ---------------------------------------------------------------------------
// ifr_out_if
// Result channel: payload byte or frame end report per item.
// ---------------------------------------------------------------------------
interface ifr_out_if;
    logic                        valid;
    logic                        ready;
    logic [ifr_pkg::KIND_W-1:0]  result_kind;
    logic [ifr_pkg::BYTE_W-1:0]  payload_byte;
    logic [ifr_pkg::LEN_W-1:0]   payload_length;

    modport source (output valid, output result_kind, output payload_byte,
                    output payload_length, input ready);
    modport sink   (input valid, input result_kind, input payload_byte,
                    input payload_length, output ready);
endinterface

### src/ifr_cfg.sv
// ---------------------------------------------------------------------------
// ifr_cfg
// APB register file holding the frame delimiters and header bytes.
// ---------------------------------------------------------------------------
module ifr_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ifr_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [ifr_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ifr_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    output ifr_pkg::ifr_cfg_t                  cfg
);

    ifr_pkg::ifr_cfg_t                  cfg_reg;
    logic [ifr_pkg::REG_IDX_W-1:0]      idx;
    logic [ifr_pkg::BYTE_W-1:0]         wbyte;
    logic [ifr_pkg::BYTE_W-1:0]         rbyte;
    logic                               wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[ifr_pkg::CFG_ADDR_W-1:2];
    assign wbyte  = pwdata[ifr_pkg::BYTE_W-1:0];
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expected_control    <= 8'd0;
            cfg_reg.address_byte        <= 8'd3;
            cfg_reg.flag_byte           <= 8'd126;
            cfg_reg.escape_byte         <= 8'd125;
            cfg_reg.escaped_flag_code   <= 8'd94;
            cfg_reg.escaped_escape_code <= 8'd93;
        end
        else if (wr_en)
        begin
            unique case (idx)
                ifr_pkg::REG_EXP_CTRL: cfg_reg.expected_control    <= wbyte;
                ifr_pkg::REG_ADDRESS:  cfg_reg.address_byte        <= wbyte;
                ifr_pkg::REG_FLAG:     cfg_reg.flag_byte           <= wbyte;
                ifr_pkg::REG_ESCAPE:   cfg_reg.escape_byte         <= wbyte;
                ifr_pkg::REG_ESC_FLAG: cfg_reg.escaped_flag_code   <= wbyte;
                ifr_pkg::REG_ESC_ESC:  cfg_reg.escaped_escape_code <= wbyte;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            ifr_pkg::REG_EXP_CTRL: rbyte = cfg_reg.expected_control;
            ifr_pkg::REG_ADDRESS:  rbyte = cfg_reg.address_byte;
            ifr_pkg::REG_FLAG:     rbyte = cfg_reg.flag_byte;
            ifr_pkg::REG_ESCAPE:   rbyte = cfg_reg.escape_byte;
            ifr_pkg::REG_ESC_FLAG: rbyte = cfg_reg.escaped_flag_code;
            ifr_pkg::REG_ESC_ESC:  rbyte = cfg_reg.escaped_escape_code;
            default:               rbyte = '0;
        endcase
    end

    assign prdata = {{(ifr_pkg::APB_DATA_W-ifr_pkg::BYTE_W){1'b0}}, rbyte};

endmodule

### src/ifr_front.sv
// ---------------------------------------------------------------------------
// ifr_front
// Frame parser: header check, destuffing, one-byte hold-back, check and
// overflow tracking. Pushes at most one result per item into the queue.
// ---------------------------------------------------------------------------
module ifr_front #(
    parameter int MAX_PAYLOAD = 1024
) (
    input  logic                  clk,
    input  logic                  rst_n,
    ifr_in_if.sink                rx_in,
    input  ifr_pkg::ifr_cfg_t     cfg,
    input  logic                  q_full,
    output logic                  q_push,
    output ifr_pkg::ifr_result_t  q_item
);

    localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PAYLOAD);

    ifr_pkg::ifr_phase_t           phase_reg, phase_next;
    logic [ifr_pkg::BYTE_W-1:0]    held_byte_reg, held_byte_next;
    logic                          held_valid_reg, held_valid_next;
    logic [ifr_pkg::BYTE_W-1:0]    xor_reg, xor_next;
    logic [CNT_W-1:0]              count_reg, count_next;

    logic                          fire;
    logic                          act;
    logic [ifr_pkg::BYTE_W-1:0]    b;
    logic                          is_flag, is_esc;
    logic                          acc_en, ovf_hit, take;
    logic [ifr_pkg::BYTE_W-1:0]    acc_d;
    logic                          emit;
    logic                          clear_en;
    ifr_pkg::ifr_phase_t           fail_phase;
    logic [CNT_W+ifr_pkg::LEN_W-1:0] len_ext;

    assign rx_in.ready = !q_full;
    assign fire        = rx_in.valid && rx_in.ready;
    assign act         = rx_in.action;
    assign b           = rx_in.rx_byte;
    assign is_flag     = (b == cfg.flag_byte);
    assign is_esc      = (b == cfg.escape_byte);
    assign fail_phase  = is_flag ? ifr_pkg::PH_FLAG : ifr_pkg::PH_HUNT;
    assign len_ext     = {{ifr_pkg::LEN_W{1'b0}}, count_reg};

    // destuffed byte offered to the hold-back stage
    always_comb
    begin
        acc_en = 1'b0;
        acc_d  = b;
        if (!act)
        begin
            unique case (phase_reg)
                ifr_pkg::PH_DATA: acc_en = !is_esc && !is_flag;
                ifr_pkg::PH_ESC:
                begin
                    if (b == cfg.escaped_flag_code)
                    begin
                        acc_en = 1'b1;
                        acc_d  = cfg.flag_byte;
                    end
                    else if (b == cfg.escaped_escape_code)
                    begin
                        acc_en = 1'b1;
                        acc_d  = cfg.escape_byte;
                    end
                end
                default: ;
            endcase
        end
    end

    assign ovf_hit = acc_en && held_valid_reg && (count_reg == CNT_MAX);
    assign take    = acc_en && !ovf_hit;

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        if (act)
        begin
            phase_next = ifr_pkg::PH_HUNT;
        end
        else
        begin
            unique case (phase_reg)
                ifr_pkg::PH_HUNT:
                    if (is_flag) phase_next = ifr_pkg::PH_FLAG;
                ifr_pkg::PH_FLAG:
                    phase_next = (b == cfg.address_byte) ? ifr_pkg::PH_ADDR : fail_phase;
                ifr_pkg::PH_ADDR:
                    phase_next = (b == cfg.expected_control) ? ifr_pkg::PH_CTRL
                                                             : fail_phase;
                ifr_pkg::PH_CTRL:
                    phase_next = (b == (cfg.address_byte ^ cfg.expected_control))
                                 ? ifr_pkg::PH_DATA : fail_phase;
                ifr_pkg::PH_DATA:
                begin
                    if (is_esc)
                        phase_next = ifr_pkg::PH_ESC;
                    else if (is_flag)
                        phase_next = ifr_pkg::PH_DONE;
                    else
                        phase_next = ovf_hit ? ifr_pkg::PH_OVF : ifr_pkg::PH_DATA;
                end
                ifr_pkg::PH_ESC:
                    phase_next = ovf_hit ? ifr_pkg::PH_OVF : ifr_pkg::PH_DATA;
                ifr_pkg::PH_DONE:
                    phase_next = ifr_pkg::PH_DONE;
                ifr_pkg::PH_OVF:
                    if (is_flag) phase_next = ifr_pkg::PH_DONE;
                default:
                    phase_next = ifr_pkg::PH_HUNT;
            endcase
        end
    end

    // result item
    always_comb
    begin
        emit                  = 1'b0;
        q_item.result_kind    = ifr_pkg::KIND_BYTE;
        q_item.payload_byte   = '0;
        q_item.payload_length = '0;
        if (!act)
        begin
            unique case (phase_reg)
                ifr_pkg::PH_DATA, ifr_pkg::PH_ESC:
                begin
                    if (phase_reg == ifr_pkg::PH_DATA && !is_esc && is_flag)
                    begin
                        emit                  = 1'b1;
                        q_item.result_kind    = (held_valid_reg && xor_reg == '0)
                                                ? ifr_pkg::KIND_GOOD : ifr_pkg::KIND_BAD;
                        q_item.payload_length = len_ext[ifr_pkg::LEN_W-1:0];
                    end
                    else if (take && held_valid_reg)
                    begin
                        emit                = 1'b1;
                        q_item.payload_byte = held_byte_reg;
                    end
                end
                ifr_pkg::PH_OVF:
                begin
                    if (is_flag)
                    begin
                        emit                  = 1'b1;
                        q_item.result_kind    = ifr_pkg::KIND_OVF;
                        q_item.payload_length = len_ext[ifr_pkg::LEN_W-1:0];
                    end
                end
                default: ;
            endcase
        end
    end

    assign q_push   = fire && emit;
    // every entry to flag-seen is an opening flag
    assign clear_en = act || (phase_next == ifr_pkg::PH_FLAG);

    always_comb
    begin
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        xor_next        = xor_reg;
        count_next      = count_reg;
        if (clear_en)
        begin
            held_byte_next  = '0;
            held_valid_next = 1'b0;
            xor_next        = '0;
            count_next      = '0;
        end
        else if (take)
        begin
            held_byte_next  = acc_d;
            held_valid_next = 1'b1;
            xor_next        = xor_reg ^ acc_d;
            if (held_valid_reg)
                count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= ifr_pkg::PH_HUNT;
            held_byte_reg  <= '0;
            held_valid_reg <= 1'b0;
            xor_reg        <= '0;
            count_reg      <= '0;
        end
        else if (fire)
        begin
            phase_reg      <= phase_next;
            held_byte_reg  <= held_byte_next;
            held_valid_reg <= held_valid_next;
            xor_reg        <= xor_next;
            count_reg      <= count_next;
        end
    end

endmodule

### src/ifr_fifo.sv
// ---------------------------------------------------------------------------
// ifr_fifo
// Short result queue between parser and output stage.
// ---------------------------------------------------------------------------
module ifr_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  ifr_pkg::ifr_result_t  wdata,
    output logic                  full,
    input  logic                  pop,
    output ifr_pkg::ifr_result_t  rdata,
    output logic                  empty
);

    localparam int PTR_W = (ifr_pkg::QDEPTH > 1) ? $clog2(ifr_pkg::QDEPTH) : 1;
    localparam int CNT_W = $clog2(ifr_pkg::QDEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(ifr_pkg::QDEPTH);

    ifr_pkg::ifr_result_t   mem_reg [ifr_pkg::QDEPTH];
    logic [PTR_W-1:0]       wptr_reg, wptr_next;
    logic [PTR_W-1:0]       rptr_reg, rptr_next;
    logic [CNT_W-1:0]       count_reg, count_next;

    assign full  = (count_reg == CNT_FULL);
    assign empty = (count_reg == '0);
    assign rdata = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next  = pop  ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

### src/ifr_back.sv
// ---------------------------------------------------------------------------
// ifr_back
// Output register: pulls results from the queue and holds them until taken.
// ---------------------------------------------------------------------------
module ifr_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_empty,
    input  ifr_pkg::ifr_result_t  q_item,
    output logic                  q_pop,
    ifr_out_if.source             res_out
);

    logic                  valid_reg, valid_next;
    ifr_pkg::ifr_result_t  data_reg;

    assign q_pop = !q_empty && (!valid_reg || res_out.ready);

    always_comb
    begin
        valid_next = valid_reg;
        if (q_pop)
            valid_next = 1'b1;
        else if (res_out.ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            data_reg <= q_item;
    end

    assign res_out.valid          = valid_reg;
    assign res_out.result_kind    = data_reg.result_kind;
    assign res_out.payload_byte   = data_reg.payload_byte;
    assign res_out.payload_length = data_reg.payload_length;

endmodule

### src/info_frame_receiver.sv
// ---------------------------------------------------------------------------
// info_frame_receiver
// Byte-stuffed information frame receiver: parser front end, result queue,
// registered output stage, APB configuration registers.
// ---------------------------------------------------------------------------
//  channel   dir   handshake        payload
//  rx_in     in    valid/ready      action, rx_byte
//  res_out   out   valid/ready      result_kind, payload_byte, payload_length
//  apb       in    psel/penable     paddr, pwdata, prdata (pready tied high)
//
//  One item per cycle unless the queue is full; the parser decides each byte
//  in the cycle it is accepted. A result reaches res_out via the queue, then
//  the output register. rx_in stalls only while the two-entry queue is full.
//  rst_n clears the parser to hunt and loads the register reset values.
// ---------------------------------------------------------------------------
`include "info_frame_receiver_assert.svh"

module info_frame_receiver #(
    parameter int MAX_PAYLOAD = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    ifr_in_if.sink                             rx_in,
    ifr_out_if.source                          res_out,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ifr_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [ifr_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ifr_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);

    ifr_pkg::ifr_cfg_t     cfg;
    logic                  q_push, q_full, q_pop, q_empty;
    ifr_pkg::ifr_result_t  q_wdata, q_rdata;

    ifr_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ifr_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx_in  (rx_in),
        .cfg    (cfg),
        .q_full (q_full),
        .q_push (q_push),
        .q_item (q_wdata)
    );

    ifr_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    ifr_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_item  (q_rdata),
        .q_pop   (q_pop),
        .res_out (res_out)
    );

    `IFR_ASSERT_IMP(a_no_push_full, q_push, !q_full, "push into full result queue")
    `IFR_ASSERT_IMP(a_no_pop_empty, q_pop, !q_empty, "pop from empty result queue")
    `IFR_ASSERT_NXT(a_push_lands, q_push && !q_pop, !q_empty, "pushed result lost")
    `IFR_ASSERT_IMP(a_byte_len_zero, res_out.valid && res_out.result_kind == ifr_pkg::KIND_BYTE, res_out.payload_length == '0, "length set on payload byte")

endmodule

### sim/info_frame_receiver_tb.sv
// ---------------------------------------------------------------------------
// info_frame_receiver_tb
// Self-checking bench for the information frame receiver. Bytes and restarts
// go in on rx_in in random bursts while res_out stalls on its own pattern.
// A behavioral parser in the bench tracks each accepted item and queues the
// payload bytes and frame end reports it expects; every result taken from
// res_out is compared field by field with the oldest one. Directed frames
// cover header resync, escapes, empty and bad frames, and overflow one byte
// past full length. Random frames then run under several register settings.
// ---------------------------------------------------------------------------
module info_frame_receiver_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PAYLOAD    = 1024;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int MAX_REPORTS    = 10;
    localparam int PHASE_ITEMS    = 16;

    logic                           clk;
    logic                           rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [ifr_pkg::CFG_ADDR_W-1:0] paddr;
    logic [ifr_pkg::APB_DATA_W-1:0] pwdata;
    logic [ifr_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    ifr_in_if  rx_in ();
    ifr_out_if res_out ();

    info_frame_receiver #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx_in   (rx_in),
        .res_out (res_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // parser mirror
    ifr_pkg::ifr_cfg_t    cfg;
    ifr_pkg::ifr_phase_t  ph;
    logic [7:0]           held;
    logic                 held_v;
    logic [7:0]           xsum;
    int unsigned          emitted;
    ifr_pkg::ifr_result_t pending[$];

    logic [7:0]           line_q[$];
    int                   burst_left;
    bit                   steady_send;
    int                   items_sent;
    int                   fail_count;
    int                   idle_cycles;
    int                   sink_tick;
    int                   sink_mode;
    ifr_pkg::ifr_result_t want;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function void clear_frame();
        held    = 8'h00;
        held_v  = 1'b0;
        xsum    = 8'h00;
        emitted = 0;
    endfunction

    function void push_event(ifr_pkg::ifr_kind_t kind, logic [7:0] b,
                             logic [ifr_pkg::LEN_W-1:0] len);
        ifr_pkg::ifr_result_t r;
        r.result_kind    = kind;
        r.payload_byte   = b;
        r.payload_length = len;
        pending.push_back(r);
    endfunction

    function void take_payload(logic [7:0] d);
        if (held_v)
        begin
            if (emitted >= MAX_PAYLOAD)
            begin
                ph = ifr_pkg::PH_OVF;
                return;
            end
            push_event(ifr_pkg::KIND_BYTE, held, '0);
            emitted++;
        end
        held   = d;
        held_v = 1'b1;
        xsum   = xsum ^ d;
        ph     = ifr_pkg::PH_DATA;
    endfunction

    function void header_miss(logic [7:0] b);
        if (b == cfg.flag_byte)
        begin
            ph = ifr_pkg::PH_FLAG;
            clear_frame();
        end
        else
            ph = ifr_pkg::PH_HUNT;
    endfunction

    function void track_frame(logic act, logic [7:0] b);
        if (act)
        begin
            ph = ifr_pkg::PH_HUNT;
            clear_frame();
            return;
        end
        case (ph)
            ifr_pkg::PH_HUNT:
                if (b == cfg.flag_byte)
                begin
                    ph = ifr_pkg::PH_FLAG;
                    clear_frame();
                end
            ifr_pkg::PH_FLAG:
                if (b == cfg.address_byte)
                    ph = ifr_pkg::PH_ADDR;
                else
                    header_miss(b);
            ifr_pkg::PH_ADDR:
                if (b == cfg.expected_control)
                    ph = ifr_pkg::PH_CTRL;
                else
                    header_miss(b);
            ifr_pkg::PH_CTRL:
                if (b == (cfg.address_byte ^ cfg.expected_control))
                    ph = ifr_pkg::PH_DATA;
                else
                    header_miss(b);
            ifr_pkg::PH_DATA:
                if (b == cfg.escape_byte)
                    ph = ifr_pkg::PH_ESC;
                else if (b == cfg.flag_byte)
                begin
                    ph = ifr_pkg::PH_DONE;
                    if (!held_v)
                        push_event(ifr_pkg::KIND_BAD, 8'h00, '0);
                    else
                        push_event(xsum == 8'h00 ? ifr_pkg::KIND_GOOD : ifr_pkg::KIND_BAD,
                                   8'h00, ifr_pkg::LEN_W'(emitted));
                end
                else
                    take_payload(b);
            ifr_pkg::PH_ESC:
                if (b == cfg.escaped_flag_code)
                    take_payload(cfg.flag_byte);
                else if (b == cfg.escaped_escape_code)
                    take_payload(cfg.escape_byte);
                else
                    ph = ifr_pkg::PH_DATA;
            ifr_pkg::PH_OVF:
                if (b == cfg.flag_byte)
                begin
                    ph = ifr_pkg::PH_DONE;
                    push_event(ifr_pkg::KIND_OVF, 8'h00, ifr_pkg::LEN_W'(emitted));
                end
            default: ;
        endcase
    endfunction

    // called at a rising edge; returns at the edge that takes the item
    task automatic send_item(input logic act, input logic [7:0] b);
        int  gap;
        bit  took;
        if (burst_left <= 0 && !steady_send)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                rx_in.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        rx_in.valid   <= 1'b1;
        rx_in.action  <= act;
        rx_in.rx_byte <= b;
        do
        begin
            @(negedge clk);
            took = rx_in.ready;
            @(posedge clk);
        end
        while (!took);
        track_frame(act, b);
        burst_left--;
        items_sent++;
    endtask

    task automatic send_line(input int abort_at);
        for (int i = 0; i < line_q.size(); i++)
        begin
            if (i == abort_at)
                send_item(1'b1, 8'($urandom));
            send_item(1'b0, line_q[i]);
        end
        line_q.delete();
    endtask

    task automatic settle();
        rx_in.valid <= 1'b0;
        while (pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input ifr_pkg::ifr_reg_idx_t idx, input logic [7:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= ifr_pkg::APB_DATA_W'(v);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        case (idx)
            ifr_pkg::REG_EXP_CTRL: cfg.expected_control    = v;
            ifr_pkg::REG_ADDRESS:  cfg.address_byte        = v;
            ifr_pkg::REG_FLAG:     cfg.flag_byte           = v;
            ifr_pkg::REG_ESCAPE:   cfg.escape_byte         = v;
            ifr_pkg::REG_ESC_FLAG: cfg.escaped_flag_code   = v;
            ifr_pkg::REG_ESC_ESC:  cfg.escaped_escape_code = v;
            default: ;
        endcase
    endtask

    task automatic load_config(input ifr_pkg::ifr_cfg_t c);
        settle();
        apb_write(ifr_pkg::REG_EXP_CTRL, c.expected_control);
        apb_write(ifr_pkg::REG_ADDRESS,  c.address_byte);
        apb_write(ifr_pkg::REG_FLAG,     c.flag_byte);
        apb_write(ifr_pkg::REG_ESCAPE,   c.escape_byte);
        apb_write(ifr_pkg::REG_ESC_FLAG, c.escaped_flag_code);
        apb_write(ifr_pkg::REG_ESC_ESC,  c.escaped_escape_code);
    endtask

    function ifr_pkg::ifr_cfg_t random_config(bit distinct);
        ifr_pkg::ifr_cfg_t c;
        c = ifr_pkg::ifr_cfg_t'(48'({$urandom, $urandom}));
        if (distinct)
        begin
            while (c.escape_byte == c.flag_byte)
                c.escape_byte = 8'($urandom);
            while (c.escaped_escape_code == c.escaped_flag_code)
                c.escaped_escape_code = 8'($urandom);
        end
        return c;
    endfunction

    function void put_payload(logic [7:0] d);
        if (d == cfg.flag_byte)
        begin
            line_q.push_back(cfg.escape_byte);
            line_q.push_back(cfg.escaped_flag_code);
        end
        else if (d == cfg.escape_byte)
        begin
            line_q.push_back(cfg.escape_byte);
            line_q.push_back(cfg.escaped_escape_code);
        end
        else
            line_q.push_back(d);
    endfunction

    function logic [7:0] pick_data();
        case ($urandom_range(0, 9))
            0:       return cfg.flag_byte;
            1:       return cfg.escape_byte;
            default: return 8'($urandom);
        endcase
    endfunction

    // well-formed frame of n random payload bytes plus its check
    function void build_frame(int n);
        logic [7:0] x;
        logic [7:0] d;
        x = 8'h00;
        line_q.push_back(cfg.flag_byte);
        line_q.push_back(cfg.address_byte);
        line_q.push_back(cfg.expected_control);
        line_q.push_back(cfg.address_byte ^ cfg.expected_control);
        repeat (n)
        begin
            d = 8'($urandom);
            x = x ^ d;
            put_payload(d);
        end
        put_payload(x);
        line_q.push_back(cfg.flag_byte);
    endfunction

    task automatic send_rand_frame();
        logic [7:0] ctrl;
        logic [7:0] addr;
        logic [7:0] x;
        logic [7:0] d;
        int         len;
        int         abort_at;
        x = 8'h00;
        line_q.delete();
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 4)) line_q.push_back(8'($urandom));
        addr = ($urandom_range(0, 19) == 0) ? 8'($urandom) : cfg.address_byte;
        ctrl = ($urandom_range(0, 19) == 0) ? 8'($urandom) : cfg.expected_control;
        line_q.push_back(cfg.flag_byte);
        line_q.push_back(addr);
        line_q.push_back(ctrl);
        line_q.push_back(($urandom_range(0, 19) == 0) ? 8'($urandom) : addr ^ ctrl);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(0, 12);
        repeat (len)
        begin
            d = pick_data();
            x = x ^ d;
            put_payload(d);
            if ($urandom_range(0, 39) == 0)
            begin
                line_q.push_back(cfg.escape_byte);
                line_q.push_back(8'($urandom));
            end
        end
        if ($urandom_range(0, 19) != 0)
            put_payload(($urandom_range(0, 7) == 0) ? 8'($urandom) : x);
        if ($urandom_range(0, 19) != 0)
            line_q.push_back(cfg.flag_byte);
        abort_at = ($urandom_range(0, 24) == 0) ? $urandom_range(0, line_q.size() - 1) : -1;
        send_line(abort_at);
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 3)) send_item(1'b0, 8'($urandom));
        if ($urandom_range(0, 19) != 0)
            send_item(1'b1, 8'($urandom));
    endtask

    // wrong control, flag inside header, invalid escape, both stuffed pairs,
    // bytes after the frame end, restart carrying a flag byte
    task automatic test_header_resync_and_escapes();
        line_q = '{cfg.flag_byte, cfg.address_byte, 8'h55,
                   cfg.flag_byte, cfg.flag_byte, cfg.address_byte, cfg.expected_control,
                   cfg.address_byte ^ cfg.expected_control,
                   cfg.escape_byte, cfg.flag_byte,
                   cfg.escape_byte, cfg.escaped_flag_code,
                   cfg.escape_byte, cfg.escaped_escape_code,
                   8'h00, 8'hFF, 8'hFC, cfg.flag_byte, 8'h11};
        send_line(-1);
        send_item(1'b1, cfg.flag_byte);
    endtask

    // no byte at all, one zero check byte, wrong check
    task automatic test_empty_and_bad_check();
        line_q = '{cfg.flag_byte, cfg.address_byte, cfg.expected_control,
                   cfg.address_byte ^ cfg.expected_control, cfg.flag_byte};
        send_line(-1);
        send_item(1'b1, 8'h00);
        line_q = '{cfg.flag_byte, cfg.address_byte, cfg.expected_control,
                   cfg.address_byte ^ cfg.expected_control, 8'h00, cfg.flag_byte};
        send_line(-1);
        send_item(1'b1, 8'hFF);
        line_q = '{cfg.flag_byte, cfg.address_byte, cfg.expected_control,
                   cfg.address_byte ^ cfg.expected_control, 8'h01, 8'h02, 8'h00,
                   cfg.flag_byte};
        send_line(-1);
        send_item(1'b1, 8'h00);
    endtask

    // full length emitted, then the check byte is one too many
    task automatic test_overflow();
        build_frame(MAX_PAYLOAD + 1);
        send_line(-1);
        send_item(1'b1, 8'h00);
    endtask

    task automatic test_random_traffic();
        ifr_pkg::ifr_cfg_t c;
        int                phase_end;
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0: c = '{8'h00, 8'h03, 8'h7E, 8'h7D, 8'h5E, 8'h5D};
                1: c = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF};
                2: c = random_config(1'b1);
                3: c = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00};
                4: c = random_config(1'b1);
                default: c = random_config(1'b0);
            endcase
            load_config(c);
            steady_send = (p == 2);
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
                send_rand_frame();
        end
        steady_send = 1'b0;
    endtask

    // result side: ready follows a randomly chosen stall pattern
    always @(posedge clk)
    begin
        if (!rst_n)
            res_out.ready <= 1'b0;
        else
        begin
            sink_tick++;
            if (sink_tick % 200 == 0)
                sink_mode = $urandom_range(0, 3);
            case (sink_mode)
                0:       res_out.ready <= 1'b1;
                1:       res_out.ready <= ($urandom_range(0, 3) != 0);
                2:       res_out.ready <= (sink_tick % 4 != 3);
                default: res_out.ready <= (sink_tick % 5 < 2);
            endcase
        end
    end

    // handshakes complete at the next rising edge
    always @(negedge clk)
    begin
        if (rst_n && res_out.valid && res_out.ready)
        begin
            if (pending.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t: unexpected item kind %0d byte %h length %0d", $realtime,
                             res_out.result_kind, res_out.payload_byte,
                             res_out.payload_length);
            end
            else
            begin
                want = pending.pop_front();
                if (want.result_kind !== res_out.result_kind
                    || want.payload_byte !== res_out.payload_byte
                    || want.payload_length !== res_out.payload_length)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: mismatch kind %0d/%0d byte %h/%h length %0d/%0d",
                                 $realtime, want.result_kind, res_out.result_kind,
                                 want.payload_byte, res_out.payload_byte,
                                 want.payload_length, res_out.payload_length);
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n || (rx_in.valid && rx_in.ready) || (res_out.valid && res_out.ready) || psel)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        rx_in.valid   = 1'b0;
        rx_in.action  = 1'b0;
        rx_in.rx_byte = 8'h00;
        res_out.ready = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        cfg           = '{8'h00, 8'h03, 8'h7E, 8'h7D, 8'h5E, 8'h5D};
        ph            = ifr_pkg::PH_HUNT;
        clear_frame();
        burst_left    = 0;
        steady_send   = 1'b0;
        items_sent    = 0;
        fail_count    = 0;
        idle_cycles   = 0;
        sink_tick     = 0;
        sink_mode     = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_header_resync_and_escapes();
        test_empty_and_bad_check();
        test_overflow();
        test_random_traffic();

        settle();
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
